// ===== hw/rtl/vertex_rotate_project_core_assert.svh =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_core assertion macros
// Concurrent property wrappers used by the asserting file.
// ----------------------------------------------------------------------------
`ifndef VERTEX_ROTATE_PROJECT_CORE_ASSERT_SVH
`define VERTEX_ROTATE_PROJECT_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VRP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define VRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/vrp_pkg.sv =====
// ----------------------------------------------------------------------------
// vrp_pkg
// Widths, types and helpers of the vertex rotate and project pipeline.
// ----------------------------------------------------------------------------
package vrp_pkg;

    localparam int COORD_BITS = 24;
    localparam int FRAC_BITS  = 8;
    localparam int TRIG_BITS  = 16;
    localparam int TRIG_SHIFT = 14;

    localparam int CW      = COORD_BITS;
    localparam int UW      = CW - 1;
    localparam int PROD_W  = CW + TRIG_BITS;
    localparam int RSUM_W  = PROD_W + 1;
    localparam int ROT_W   = RSUM_W - TRIG_SHIFT;
    localparam int DIFF_W  = ROT_W + 1;
    localparam int MUL_W   = UW + DIFF_W;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (CW + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QB      = DIV_STAGES * DIV_STEPS;
    localparam int LATENCY = 7 + DIV_STAGES;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [TRIG_BITS-1:0] COS_RST = TRIG_BITS'(16384);
    localparam logic [UW-1:0] FOCAL_RST = UW'(100 * (2 ** FRAC_BITS));
    localparam logic [UW-1:0] NEAR_RST  = UW'(10 * (2 ** FRAC_BITS));
    localparam logic [UW-1:0] FAR_RST   = UW'(1000 * (2 ** FRAC_BITS));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROT_COS = 3'd0,
        CFG_ROT_SIN = 3'd1,
        CFG_CAM_X   = 3'd2,
        CFG_CAM_Y   = 3'd3,
        CFG_CAM_Z   = 3'd4,
        CFG_FOCAL   = 3'd5,
        CFG_NEAR    = 3'd6,
        CFG_FAR     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [TRIG_BITS-1:0] rot_cos;
        logic signed [TRIG_BITS-1:0] rot_sin;
        logic signed [CW-1:0]        cam_x;
        logic signed [CW-1:0]        cam_y;
        logic signed [CW-1:0]        cam_z;
        logic [UW-1:0]               focal_len;
        logic [UW-1:0]               near_depth;
        logic [UW-1:0]               far_depth;
    } t_cfg;

    typedef struct packed {
        logic signed [CW-1:0] vert_x;
        logic signed [CW-1:0] vert_y;
        logic signed [CW-1:0] vert_z;
    } t_vert;

    typedef struct packed {
        logic signed [CW-1:0] screen_x;
        logic signed [CW-1:0] screen_y;
        logic                 visible;
    } t_result;

    typedef struct packed {
        logic                     vld;
        logic                     vis;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic [CW-1:0]            den;
    } t_geom;

    typedef struct packed {
        logic          neg;
        logic          ovf;
        logic [CW-1:0] rem;
        logic [QB-1:0] q;
        logic [QB-1:0] low;
    } t_div_lane;

    typedef struct packed {
        logic          vld;
        logic          vis;
        logic [CW-1:0] den;
        t_div_lane     lx;
        t_div_lane     ly;
    } t_div_item;

    function automatic t_div_lane div_lane_step(t_div_lane l, logic [CW-1:0] den);
        t_div_lane o;
        logic [CW:0] r2;
        o = l;
        for (int i = 0; i < DIV_STEPS; i++) begin
            r2    = {o.rem, o.low[QB-1]};
            o.low = {o.low[QB-2:0], 1'b0};
            if (r2 >= {1'b0, den}) begin
                r2  = r2 - {1'b0, den};
                o.q = {o.q[QB-2:0], 1'b1};
            end else begin
                o.q = {o.q[QB-2:0], 1'b0};
            end
            o.rem = r2[CW-1:0];
        end
        return o;
    endfunction

endpackage

// ===== hw/rtl/vrp_rotate.sv =====
// ----------------------------------------------------------------------------
// vrp_rotate
// Y-axis rotation, camera offset and depth clip; three register stages.
// ----------------------------------------------------------------------------
module vrp_rotate (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    input  vrp_pkg::t_vert i_vert,
    input  vrp_pkg::t_cfg  i_cfg,
    output vrp_pkg::t_geom o_geom
);

    localparam logic signed [vrp_pkg::RSUM_W-1:0] HALF =
        vrp_pkg::RSUM_W'(2 ** (vrp_pkg::TRIG_SHIFT - 1));

    logic                               r_s1_vld;
    logic signed [vrp_pkg::PROD_W-1:0]  r_xc, r_zs, r_xs, r_zc;
    logic signed [vrp_pkg::CW-1:0]      r_s1_y;

    logic                               r_s2_vld;
    logic signed [vrp_pkg::ROT_W-1:0]   r_rx, r_rz;
    logic signed [vrp_pkg::CW-1:0]      r_s2_y;

    logic signed [vrp_pkg::RSUM_W-1:0]  n_sum_x, n_sum_z;
    logic signed [vrp_pkg::DIFF_W-1:0]  n_dx, n_dy, n_dz, n_near, n_far;
    vrp_pkg::t_geom                     r_geom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_vld;
        end
        r_xc   <= vrp_pkg::PROD_W'(i_vert.vert_x) * vrp_pkg::PROD_W'(i_cfg.rot_cos);
        r_zs   <= vrp_pkg::PROD_W'(i_vert.vert_z) * vrp_pkg::PROD_W'(i_cfg.rot_sin);
        r_xs   <= vrp_pkg::PROD_W'(i_vert.vert_x) * vrp_pkg::PROD_W'(i_cfg.rot_sin);
        r_zc   <= vrp_pkg::PROD_W'(i_vert.vert_z) * vrp_pkg::PROD_W'(i_cfg.rot_cos);
        r_s1_y <= i_vert.vert_y;
    end

    always_comb begin
        n_sum_x = vrp_pkg::RSUM_W'(r_xc) + vrp_pkg::RSUM_W'(r_zs) + HALF;
        n_sum_z = vrp_pkg::RSUM_W'(r_zc) - vrp_pkg::RSUM_W'(r_xs) + HALF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_rx   <= n_sum_x[vrp_pkg::RSUM_W-1:vrp_pkg::TRIG_SHIFT];
        r_rz   <= n_sum_z[vrp_pkg::RSUM_W-1:vrp_pkg::TRIG_SHIFT];
        r_s2_y <= r_s1_y;
    end

    always_comb begin
        n_dx   = vrp_pkg::DIFF_W'(r_rx) - vrp_pkg::DIFF_W'(i_cfg.cam_x);
        n_dz   = vrp_pkg::DIFF_W'(r_rz) - vrp_pkg::DIFF_W'(i_cfg.cam_z);
        n_dy   = vrp_pkg::DIFF_W'(r_s2_y) - vrp_pkg::DIFF_W'(i_cfg.cam_y);
        n_near = $signed({{(vrp_pkg::DIFF_W - vrp_pkg::UW){1'b0}}, i_cfg.near_depth});
        n_far  = $signed({{(vrp_pkg::DIFF_W - vrp_pkg::UW){1'b0}}, i_cfg.far_depth});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.vld <= 1'b0;
        end else begin
            r_geom.vld <= r_s2_vld;
        end
        r_geom.vis <= (n_dz > n_near) && (n_dz < n_far);
        r_geom.dx  <= n_dx;
        r_geom.dy  <= n_dy;
        // dz below 2^(CW-1) whenever the vertex is kept
        r_geom.den <= {1'b0, i_cfg.focal_len} + n_dz[vrp_pkg::CW-1:0];
    end

    assign o_geom = r_geom;

endmodule

// ===== hw/rtl/vrp_div_stage.sv =====
// ----------------------------------------------------------------------------
// vrp_div_stage
// One registered radix-4 restoring step for both screen lanes.
// ----------------------------------------------------------------------------
module vrp_div_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vrp_pkg::t_div_item i_item,
    output vrp_pkg::t_div_item o_item
);

    vrp_pkg::t_div_item r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item.vld <= 1'b0;
        end else begin
            r_item.vld <= i_item.vld;
        end
        r_item.vis <= i_item.vis;
        r_item.den <= i_item.den;
        r_item.lx  <= vrp_pkg::div_lane_step(i_item.lx, i_item.den);
        r_item.ly  <= vrp_pkg::div_lane_step(i_item.ly, i_item.den);
    end

    assign o_item = r_item;

endmodule

// ===== hw/rtl/vrp_project.sv =====
// ----------------------------------------------------------------------------
// vrp_project
// Perspective divide: magnitude, focal multiply, pipelined divide, saturate.
// ----------------------------------------------------------------------------
module vrp_project (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  vrp_pkg::t_geom   i_geom,
    input  vrp_pkg::t_cfg    i_cfg,
    output logic             o_vld,
    output vrp_pkg::t_result o_result
);

    localparam logic [vrp_pkg::QB:0] CAP = (vrp_pkg::QB + 1)'(2 ** (vrp_pkg::CW - 1));

    logic                         r_s4_vld, r_s4_vis, r_s4_nx, r_s4_ny;
    logic [vrp_pkg::DIFF_W-1:0]   r_mx, r_my;
    logic [vrp_pkg::CW-1:0]       r_s4_den;

    logic                         r_s5_vld, r_s5_vis, r_s5_nx, r_s5_ny;
    logic [vrp_pkg::MUL_W-1:0]    r_px, r_py;
    logic [vrp_pkg::CW-1:0]       r_s5_den;

    vrp_pkg::t_div_item           r_s6;
    vrp_pkg::t_div_item           w_div [vrp_pkg::DIV_STAGES+1];

    logic                         r_vld;
    vrp_pkg::t_result             r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= i_geom.vld;
        end
        r_s4_vis <= i_geom.vis;
        r_s4_nx  <= i_geom.dx[vrp_pkg::DIFF_W-1];
        r_s4_ny  <= i_geom.dy[vrp_pkg::DIFF_W-1];
        r_mx     <= i_geom.dx[vrp_pkg::DIFF_W-1] ? -i_geom.dx : i_geom.dx;
        r_my     <= i_geom.dy[vrp_pkg::DIFF_W-1] ? -i_geom.dy : i_geom.dy;
        r_s4_den <= i_geom.den;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else begin
            r_s5_vld <= r_s4_vld;
        end
        r_s5_vis <= r_s4_vis;
        r_s5_nx  <= r_s4_nx;
        r_s5_ny  <= r_s4_ny;
        r_px     <= vrp_pkg::MUL_W'(i_cfg.focal_len) * vrp_pkg::MUL_W'(r_mx);
        r_py     <= vrp_pkg::MUL_W'(i_cfg.focal_len) * vrp_pkg::MUL_W'(r_my);
        r_s5_den <= r_s4_den;
    end

    // high part at or above den: quotient needs more than QB bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6.vld <= 1'b0;
        end else begin
            r_s6.vld <= r_s5_vld;
        end
        r_s6.vis    <= r_s5_vis;
        r_s6.den    <= r_s5_den;
        r_s6.lx.neg <= r_s5_nx;
        r_s6.ly.neg <= r_s5_ny;
        r_s6.lx.ovf <= r_px[vrp_pkg::MUL_W-1:vrp_pkg::QB] >=
                       (vrp_pkg::MUL_W - vrp_pkg::QB)'(r_s5_den);
        r_s6.ly.ovf <= r_py[vrp_pkg::MUL_W-1:vrp_pkg::QB] >=
                       (vrp_pkg::MUL_W - vrp_pkg::QB)'(r_s5_den);
        r_s6.lx.rem <= r_px[vrp_pkg::QB+vrp_pkg::CW-1:vrp_pkg::QB];
        r_s6.ly.rem <= r_py[vrp_pkg::QB+vrp_pkg::CW-1:vrp_pkg::QB];
        r_s6.lx.low <= r_px[vrp_pkg::QB-1:0];
        r_s6.ly.low <= r_py[vrp_pkg::QB-1:0];
        r_s6.lx.q   <= '0;
        r_s6.ly.q   <= '0;
    end

    assign w_div[0] = r_s6;

    for (genvar g = 0; g < vrp_pkg::DIV_STAGES; g++) begin : g_div
        vrp_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_item  (w_div[g]),
            .o_item  (w_div[g+1])
        );
    end

    function automatic logic signed [vrp_pkg::CW-1:0] saturate(vrp_pkg::t_div_lane l);
        logic [vrp_pkg::QB:0] q;
        logic [vrp_pkg::QB:0] v;
        q = {1'b0, l.q};
        if (l.neg) begin
            v = (l.ovf || q > CAP) ? CAP : q;
            return -vrp_pkg::CW'(v);
        end
        v = (l.ovf || q >= CAP) ? CAP - 1'b1 : q;
        return vrp_pkg::CW'(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= w_div[vrp_pkg::DIV_STAGES].vld;
        end
        r_result.visible  <= w_div[vrp_pkg::DIV_STAGES].vis;
        r_result.screen_x <= w_div[vrp_pkg::DIV_STAGES].vis ?
                             saturate(w_div[vrp_pkg::DIV_STAGES].lx) : '0;
        r_result.screen_y <= w_div[vrp_pkg::DIV_STAGES].vis ?
                             saturate(w_div[vrp_pkg::DIV_STAGES].ly) : '0;
    end

    assign o_vld    = r_vld;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/vertex_rotate_project_core.sv =====
// ----------------------------------------------------------------------------
// vertex_rotate_project_core
// Rotates a vertex about y, offsets by the camera, clips on depth and
// projects it onto the screen plane.
// ----------------------------------------------------------------------------
// One request is taken every clock (busy stays low); each gives exactly one
// result, strobed on o_done for a single cycle, after it has passed the
// rotate stages and the pipelined divider that retires two quotient bits
// per stage, then the output saturation register. Results cannot be held off.
// Configuration writes take effect at once and belong in idle periods.
module vertex_rotate_project_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  vrp_pkg::t_vert                  i_vert,
    output logic                            o_done,
    output vrp_pkg::t_result                o_result,
    input  logic                            i_cfg_we,
    input  logic [vrp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [vrp_pkg::CW-1:0]          i_cfg_data
);

`include "vertex_rotate_project_core_assert.svh"

    vrp_pkg::t_cfg  r_cfg;
    vrp_pkg::t_geom w_geom;
    logic           w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rot_cos    <= vrp_pkg::COS_RST;
            r_cfg.rot_sin    <= '0;
            r_cfg.cam_x      <= '0;
            r_cfg.cam_y      <= '0;
            r_cfg.cam_z      <= '0;
            r_cfg.focal_len  <= vrp_pkg::FOCAL_RST;
            r_cfg.near_depth <= vrp_pkg::NEAR_RST;
            r_cfg.far_depth  <= vrp_pkg::FAR_RST;
        end else if (i_cfg_we) begin
            case (vrp_pkg::t_cfg_idx'(i_cfg_idx))
                vrp_pkg::CFG_ROT_COS: r_cfg.rot_cos    <= i_cfg_data[vrp_pkg::TRIG_BITS-1:0];
                vrp_pkg::CFG_ROT_SIN: r_cfg.rot_sin    <= i_cfg_data[vrp_pkg::TRIG_BITS-1:0];
                vrp_pkg::CFG_CAM_X:   r_cfg.cam_x      <= i_cfg_data;
                vrp_pkg::CFG_CAM_Y:   r_cfg.cam_y      <= i_cfg_data;
                vrp_pkg::CFG_CAM_Z:   r_cfg.cam_z      <= i_cfg_data;
                vrp_pkg::CFG_FOCAL:   r_cfg.focal_len  <= i_cfg_data[vrp_pkg::UW-1:0];
                vrp_pkg::CFG_NEAR:    r_cfg.near_depth <= i_cfg_data[vrp_pkg::UW-1:0];
                vrp_pkg::CFG_FAR:     r_cfg.far_depth  <= i_cfg_data[vrp_pkg::UW-1:0];
                default: begin
                end
            endcase
        end
    end

    vrp_rotate u_rotate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_accept),
        .i_vert  (i_vert),
        .i_cfg   (r_cfg),
        .o_geom  (w_geom)
    );

    vrp_project u_project (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_geom   (w_geom),
        .i_cfg    (r_cfg),
        .o_vld    (o_done),
        .o_result (o_result)
    );

    `VRP_ASSERT_IMP(a_done_latency, i_clk, i_rst_n, o_done && $past(i_rst_n, vrp_pkg::LATENCY), $past(w_accept, vrp_pkg::LATENCY))
    `VRP_ASSERT_IMP(a_clip_zero, i_clk, i_rst_n, o_done && !o_result.visible, o_result.screen_x == '0 && o_result.screen_y == '0)
    `VRP_ASSERT_NEXT(a_geom_to_s4, i_clk, i_rst_n, w_geom.vld, u_project.r_s4_vld)

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertex_rotate_project_core. Vertices are sent with
// random gaps; a scoreboard predicts each projected point from its own model
// of the rotation, depth clip and saturating divide and compares every strobed
// result in order. Register settings are changed only while idle, after a drain.
// ----------------------------------------------------------------------------
module tb;
    import vrp_pkg::*;

    localparam int SAT_HI = (1 << (CW - 1)) - 1;
    localparam int SAT_LO = -(1 << (CW - 1));

    class proj_board;
        t_result exp_q[$];
        int      errors;
        logic signed [15:0]   cosv, sinv;
        logic signed [CW-1:0] cx, cy, cz;
        logic [UW-1:0]        focal, near_d, far_d;

        function new();
            cosv = 16384; sinv = 0; cx = 0; cy = 0; cz = 0;
            focal = FOCAL_RST; near_d = NEAR_RST; far_d = FAR_RST;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CW-1:0] v);
            case (idx)
                CFG_ROT_COS: cosv = v[15:0];
                CFG_ROT_SIN: sinv = v[15:0];
                CFG_CAM_X:   cx = v;
                CFG_CAM_Y:   cy = v;
                CFG_CAM_Z:   cz = v;
                CFG_FOCAL:   focal = v[UW-1:0];
                CFG_NEAR:    near_d = v[UW-1:0];
                default:     far_d = v[UW-1:0];
            endcase
        endfunction

        function logic signed [CW-1:0] divide_sat(longint d, longint den);
            logic signed [127:0] num, q;
            num = 128'(signed'(d)) * 128'(signed'(longint'(focal)));
            q = num / 128'(signed'(den));
            if (q > SAT_HI) return CW'(SAT_HI);
            if (q < SAT_LO) return CW'(SAT_LO);
            return q[CW-1:0];
        endfunction

        function void note_vertex(t_vert v);
            longint x, y, z, rx, rz, dz, den;
            t_result r;
            x = v.vert_x; y = v.vert_y; z = v.vert_z;
            // floor of (sum + half) / 2^14: rounds ties upward
            rx = (x * cosv + z * sinv + 8192) >>> 14;
            rz = (-(x * sinv) + z * cosv + 8192) >>> 14;
            dz = rz - cz;
            r = '0;
            if (dz > longint'(near_d) && dz < longint'(far_d)) begin
                den = longint'(focal) + dz;
                r.screen_x = divide_sat(rx - cx, den);
                r.screen_y = divide_sat(y - cy, den);
                r.visible = 1'b1;
            end
            exp_q.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (got.screen_x !== e.screen_x || got.screen_y !== e.screen_y ||
                got.visible !== e.visible) begin
                $display("%0t: mismatch exp x=%0d y=%0d v=%0b got x=%0d y=%0d v=%0b",
                         $time, e.screen_x, e.screen_y, e.visible,
                         got.screen_x, got.screen_y, got.visible);
                errors++;
            end
        endfunction
    endclass

    logic          i_clk = 0, i_rst_n = 0, start = 0, i_cfg_we = 0;
    logic          busy, o_done;
    t_vert         i_vert = '0;
    t_result       o_result;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CW-1:0] i_cfg_data = '0;
    int            send_idle;
    proj_board     sb;

    vertex_rotate_project_core dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) sb.check_result(o_result);
    end

    // start stays high between back-to-back requests
    task automatic send_vertex(t_vert v);
        while ($urandom_range(99) < send_idle) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_vert <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        sb.note_vertex(v);
    endtask

    task automatic drain();
        int n;
        n = 0;
        start <= 1'b0;
        while (sb.exp_q.size() != 0) @(posedge i_clk);
        while (n < LATENCY + 4) begin
            @(posedge i_clk);
            n++;
        end
    endtask

    task automatic write_cfg(t_cfg_idx idx, logic [CW-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.write_reg(idx, v);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [CW-1:0] rnd_coord();
        case ($urandom_range(5))
            0: return CW'(SAT_HI);
            1: return CW'(SAT_LO);
            2: return CW'($urandom);
            default: return CW'(int'($urandom_range(120000)) - 60000);
        endcase
    endfunction

    function automatic t_vert rnd_vert();
        t_vert v;
        v.vert_x = rnd_coord();
        v.vert_y = rnd_coord();
        // mostly inside the depth window of the current setting
        v.vert_z = ($urandom_range(3) != 0) ?
                   CW'(int'($urandom_range(300000)) - 20000) : rnd_coord();
        return v;
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_vertex(rnd_vert());
    endtask

    initial begin
        sb = new();
        send_idle = 35;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // extremes, clip edges and identity rotation
        send_vertex('{CW'(SAT_HI), CW'(SAT_HI), CW'(SAT_HI)});
        send_vertex('{CW'(SAT_LO), CW'(SAT_LO), CW'(SAT_LO)});
        send_vertex('{CW'(0), CW'(0), CW'(0)});
        send_vertex('{CW'(SAT_HI), CW'(SAT_LO), CW'(2560)});
        send_vertex('{CW'(SAT_HI), CW'(SAT_LO), CW'(2561)});
        send_vertex('{CW'(SAT_LO), CW'(SAT_HI), CW'(255999)});
        send_vertex('{CW'(-1), CW'(1), CW'(256000)});
        send_vertex('{CW'(1000), CW'(-1000), CW'(5000)});
        drain();
        // focal zero, rotation at extremes, wide window
        write_cfg(CFG_FOCAL, '0);
        write_cfg(CFG_NEAR, '0);
        write_cfg(CFG_FAR, CW'(SAT_HI));
        write_cfg(CFG_ROT_COS, CW'(-16384));
        write_cfg(CFG_ROT_SIN, CW'(16384));
        send_vertex('{CW'(SAT_HI), CW'(7), CW'(SAT_LO)});
        send_vertex('{CW'(SAT_LO), CW'(-7), CW'(SAT_LO)});
        drain();
        write_cfg(CFG_FOCAL, CW'(SAT_HI));
        write_cfg(CFG_ROT_COS, CW'(16'h8000));
        write_cfg(CFG_ROT_SIN, CW'(16'h7fff));
        write_cfg(CFG_CAM_X, CW'(SAT_HI));
        write_cfg(CFG_CAM_Y, CW'(SAT_LO));
        write_cfg(CFG_CAM_Z, CW'(SAT_LO));
        send_vertex('{CW'(SAT_LO), CW'(SAT_HI), CW'(SAT_HI)});
        send_vertex('{CW'(SAT_HI), CW'(SAT_HI), CW'(SAT_LO)});
        send_vertex('{CW'(3), CW'(-3), CW'(1)});
        drain();
        // rotation 30 degrees, camera offset
        write_cfg(CFG_ROT_COS, CW'(14189));
        write_cfg(CFG_ROT_SIN, CW'(8192));
        write_cfg(CFG_CAM_X, CW'(-5000));
        write_cfg(CFG_CAM_Y, CW'(3000));
        write_cfg(CFG_CAM_Z, CW'(-2000));
        write_cfg(CFG_FOCAL, CW'(25600));
        write_cfg(CFG_NEAR, CW'(2560));
        write_cfg(CFG_FAR, CW'(256000));
        random_phase(250);
        drain();
        send_idle = 55;
        write_cfg(CFG_ROT_SIN, CW'(-11585));
        write_cfg(CFG_ROT_COS, CW'(11585));
        write_cfg(CFG_FOCAL, CW'($urandom_range(200000)));
        random_phase(250);
        drain();
        send_idle = 0;
        write_cfg(CFG_ROT_COS, CW'(16384));
        write_cfg(CFG_ROT_SIN, CW'(0));
        write_cfg(CFG_CAM_X, '0);
        write_cfg(CFG_CAM_Y, '0);
        write_cfg(CFG_CAM_Z, '0);
        write_cfg(CFG_NEAR, CW'(1));
        write_cfg(CFG_FAR, CW'(300000));
        random_phase(240);
        drain();
        if (sb.errors == 0 && sb.exp_q.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/vrp_pkg.sv
hw/rtl/vrp_rotate.sv
hw/rtl/vrp_div_stage.sv
hw/rtl/vrp_project.sv
hw/rtl/vertex_rotate_project_core.sv
verif/tb.sv
